// ===== sv/nfi_pkg.sv =====
package nfi_pkg;

  // Divider operand widths: the numerator must hold a 32x34 product.
  localparam int NUM_W  = 68;
  localparam int DEN_W  = 36;
  localparam int PROD_W = 66;
  localparam int FRAC_W = 16;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_CHECK,
    S_FETCH,
    S_PSTART,
    S_PWAIT,
    S_MUL1,
    S_CSTART,
    S_CWAIT,
    S_MUL2,
    S_TERM,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] y_result;
    logic [1:0]         status;
  } out_item_t;

  localparam logic signed [NUM_W-1:0] SAT_MAX = {{(NUM_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [NUM_W-1:0] SAT_MIN = {{(NUM_W-31){1'b1}}, {31{1'b0}}};

  function automatic logic signed [31:0] sat32(input logic signed [NUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/nfi_div.sv =====
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module nfi_div
  import nfi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] nmag_r, nmag_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] dmag_r, dmag_nxt;
  logic             neg_r, neg_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             qbit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    nmag_r <= nmag_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    nmag_nxt = nmag_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    rem_sh   = {rem_r[DEN_W-1:0], nmag_r[NUM_W-1]};
    qbit     = (rem_sh >= {1'b0, dmag_r});
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      nmag_nxt = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dmag_nxt = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      neg_nxt  = num[NUM_W-1] ^ den[DEN_W-1];
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = qbit ? (rem_sh - {1'b0, dmag_r}) : rem_sh;
      nmag_nxt = {nmag_r[NUM_W-2:0], qbit};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed(nmag_r) : $signed(nmag_r);

endmodule

// ===== sv/newton_forward_interpolator.sv =====
// Newton forward-difference interpolator, signed Q16.16. A load item appends
// an (x,y) point and extends the difference table by one diagonal of
// min(DIFF_ORDER, points held) differences, one subtraction a cycle. A clear
// item empties the table. A query scans every stored x once, then runs the
// shared 68-bit serial divider once for p and once per difference order,
// with one shared multiplier. A query with too few points goes straight to
// its result. A query always yields one result item; loads and clears yield
// none. The block takes no item while it works; the result waits in an
// output register.
module newton_forward_interpolator
  import nfi_pkg::*;
#(
  parameter int MAX_POINTS = 128,
  parameter int DIFF_ORDER = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int DAW = $clog2(MAX_POINTS * DIFF_ORDER);
  localparam int KW  = $clog2(DIFF_ORDER + 2);

  // Sample stores and difference table
  logic signed [31:0] x_mem [MAX_POINTS];
  logic signed [31:0] y_mem [MAX_POINTS];
  logic signed [31:0] d_mem [MAX_POINTS * DIFF_ORDER];

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic cmp_vld_r, cmp_vld_nxt;
  logic found_r, found_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic signed [31:0] x0_r, x0_nxt, x1_r, x1_nxt, xlast_r, xlast_nxt;
  logic signed [31:0] xq_r, xq_nxt;
  logic signed [31:0] cur_r, cur_nxt;
  logic signed [31:0] diag_r [DIFF_ORDER];
  logic signed [31:0] diag_sel;
  logic signed [31:0] p_r, p_nxt, c_r, c_nxt;
  logic signed [63:0] sum_r, sum_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [31:0] res_y_r, res_y_nxt;
  status_t res_st_r, res_st_nxt;

  logic signed [31:0] x_rdata_r, y_rdata_r, d_rdata_r;
  logic [AW-1:0]  x_raddr;
  logic [DAW-1:0] d_raddr, d_waddr;
  logic           xy_we, d_we;
  logic signed [31:0] d_wdata;
  logic [CW-1:0]  row;
  logic [CW-1:0]  lim_load, lim_base;

  logic signed [32:0] h, xdiff, ydiff;
  logic signed [33:0] factor;
  logic signed [31:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [49:0] term;

  logic                    div_start, div_done;
  logic signed [NUM_W-1:0] div_num, div_quo;
  logic signed [DEN_W-1:0] div_den;

  nfi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (xy_we) begin
      x_mem[count_r[AW-1:0]] <= in_data.x_value;
      y_mem[count_r[AW-1:0]] <= in_data.y_value;
    end
    if (d_we) begin
      d_mem[d_waddr] <= d_wdata;
    end
    x_rdata_r <= x_mem[x_raddr];
    y_rdata_r <= y_mem[base_r];
    d_rdata_r <= d_mem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
    scan_r     <= scan_nxt;
    k_r        <= k_nxt;
    base_r     <= base_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    xlast_r    <= xlast_nxt;
    xq_r       <= xq_nxt;
    cur_r      <= cur_nxt;
    p_r        <= p_nxt;
    c_r        <= c_nxt;
    sum_r      <= sum_nxt;
    prod_r     <= prod_nxt;
    res_y_r    <= res_y_nxt;
    res_st_r   <= res_st_nxt;
    // Shift the newest diagonal in, one order per load step
    for (int j = 0; j < DIFF_ORDER; j++) begin
      if (state_r == S_LOAD && k_r == KW'(j + 1)) begin
        diag_r[j] <= cur_r;
      end
    end
  end

  // Datapath helpers
  always_comb begin
    diag_sel = diag_r[0];
    for (int j = 0; j < DIFF_ORDER; j++) begin
      if (k_r == KW'(j + 1)) begin
        diag_sel = diag_r[j];
      end
    end
    h        = 33'(x1_r) - 33'(x0_r);
    xdiff    = 33'(xq_r) - 33'(x_rdata_r);
    ydiff    = 33'(cur_r) - 33'(diag_sel);
    factor   = 34'(p_r) - $signed(34'(k_r - 1'b1) << FRAC_W);
    lim_load = (count_r < CW'(DIFF_ORDER)) ? count_r : CW'(DIFF_ORDER);
    lim_base = count_r - CW'(1) - CW'(DIFF_ORDER);
    row      = count_r - CW'(k_r);
    d_waddr  = DAW'(row * DIFF_ORDER + (k_r - 1'b1));
    d_raddr  = DAW'(base_r * DIFF_ORDER + (k_r - 1'b1));
    d_wdata  = sat32(NUM_W'(ydiff));
    x_raddr  = (state_r == S_SCAN) ? scan_r[AW-1:0] : base_r;
    mul_a    = c_r;
    mul_b    = (state_r == S_MUL2) ? 34'(d_rdata_r) : factor;
    term     = 50'(prod_r >>> FRAC_W);
    if (prod_r[PROD_W-1] && (prod_r[FRAC_W-1:0] != '0)) begin
      term = term + 50'sd1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    k_nxt         = k_r;
    base_nxt      = base_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = 1'b0;
    found_nxt     = found_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    xlast_nxt     = xlast_r;
    xq_nxt        = xq_r;
    cur_nxt       = cur_r;
    p_nxt         = p_r;
    c_nxt         = c_r;
    sum_nxt       = sum_r;
    prod_nxt      = prod_r;
    res_y_nxt     = res_y_r;
    res_st_nxt    = res_st_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    xy_we         = 1'b0;
    d_we          = 1'b0;
    div_start     = 1'b0;
    div_num       = NUM_W'(prod_r);
    div_den       = $signed(DEN_W'(k_r) << FRAC_W);
    in_ready      = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.action)
            ACT_LOAD: begin
              // Drop the point when the table is full
              if (count_r < CW'(MAX_POINTS)) begin
                xy_we     = 1'b1;
                xlast_nxt = in_data.x_value;
                if (count_r == CW'(0)) x0_nxt = in_data.x_value;
                if (count_r == CW'(1)) x1_nxt = in_data.x_value;
                cur_nxt   = in_data.y_value;
                k_nxt     = KW'(1);
                state_nxt = S_LOAD;
              end
            end
            ACT_QUERY: begin
              xq_nxt = in_data.x_value;
              if (count_r < CW'(DIFF_ORDER + 1)) begin
                res_y_nxt  = '0;
                res_st_nxt = ST_FEW;
                state_nxt  = S_EMIT;
              end else begin
                scan_nxt  = '0;
                found_nxt = 1'b0;
                base_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            ACT_CLEAR: count_nxt = '0;
            ACT_NOP: ;
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        if (CW'(k_r) <= lim_load) begin
          d_we    = 1'b1;
          cur_nxt = d_wdata;
          k_nxt   = k_r + 1'b1;
        end else begin
          count_nxt = count_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        // Issue one read a cycle; compare the one issued in the previous cycle
        if (cmp_vld_r && (x_rdata_r <= xq_r)) begin
          found_nxt = 1'b1;
          base_nxt  = cmp_idx_r;
        end
        if (scan_r < count_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r[AW-1:0];
          scan_nxt    = scan_r + 1'b1;
        end else if (!cmp_vld_r) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!found_r || (xq_r > xlast_r) || (h == '0)) begin
          res_y_nxt  = '0;
          res_st_nxt = ST_RANGE;
          state_nxt  = S_EMIT;
        end else begin
          // Pull the base back so every order has a difference
          if (CW'(base_r) > lim_base) base_nxt = lim_base[AW-1:0];
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_PSTART;
      S_PSTART: begin
        div_start = 1'b1;
        div_num   = NUM_W'(xdiff) <<< FRAC_W;
        div_den   = DEN_W'(h);
        sum_nxt   = 64'(y_rdata_r);
        c_nxt     = 32'sd65536;
        k_nxt     = KW'(1);
        state_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        if (div_done) begin
          p_nxt     = sat32(div_quo);
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_CSTART;
      end
      S_CSTART: begin
        div_start = 1'b1;
        state_nxt = S_CWAIT;
      end
      S_CWAIT: begin
        if (div_done) begin
          c_nxt     = sat32(div_quo);
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_TERM;
      end
      S_TERM: begin
        sum_nxt = sum_r + 64'(term);
        if (k_r == KW'(DIFF_ORDER)) begin
          res_y_nxt  = sat32(NUM_W'(sum_nxt));
          res_st_nxt = ST_OK;
          state_nxt  = S_EMIT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_data_nxt.y_result = res_y_r;
          out_data_nxt.status   = res_st_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/nfi_chk.sv =====
module nfi_chk
  import nfi_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.y_result == 32'sd0)
    else $error("failed query with non-zero value");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action == ACT_QUERY |=> !in_ready)
    else $error("ready straight after a query");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result item out of reset");

endmodule

bind newton_forward_interpolator nfi_chk u_nfi_chk (.*);
